// ===== src/assert_macros.svh =====
// Assertion helper macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, also checked while reset is held
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/tsvg_pkg.sv =====
// ----------------------------------------------------------------------------
// Torus strip vertex generator package
// Field widths, register codes and the shared saturation helper.
// ----------------------------------------------------------------------------
package tsvg_pkg;

    // index width; counts run up to 2**COUNT_BITS
    localparam int COUNT_BITS = 12;
    localparam int CNT_W     = COUNT_BITS + 1;
    localparam int RING_W    = COUNT_BITS;
    localparam int TUBE_W    = COUNT_BITS + 1;
    localparam int RAD_W     = 31;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 32;
    localparam int NORM_W    = 18;
    localparam int TEX_W     = 17;
    localparam int SLOT_W    = 26;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 50;
    localparam int TEX_NUM_W = CNT_W + FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAJOR = 2'd0,
        CFG_MINOR = 2'd1,
        CFG_RING  = 2'd2,
        CFG_TUBE  = 2'd3
    } t_cfg_idx;

    // Clip a wide two's-complement value to signed 32 bits
    function automatic logic [POS_W-1:0] sat32(input logic [PROD_W-1:0] v);
        logic [PROD_W-POS_W:0] hi;
        hi = v[PROD_W-1:POS_W-1];
        if (hi == '0 || hi == '1)
            return v[POS_W-1:0];
        else if (v[PROD_W-1])
            return {1'b1, {(POS_W-1){1'b0}}};
        else
            return {1'b0, {(POS_W-1){1'b1}}};
    endfunction

endpackage

// ===== src/tsvg_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider, one quotient bit per register stage.
// The config divisor must be held steady by the user; it is not enforced.
// ----------------------------------------------------------------------------
module tsvg_div #(
    parameter int NUM_W = 29
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [tsvg_pkg::CNT_W-1:0]   i_den,
    output logic [NUM_W-1:0]             o_quo
);
    import tsvg_pkg::*;

    logic [CNT_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_stg
            logic [CNT_W-1:0] rem_in;
            logic [NUM_W-1:0] num_in;
            logic [NUM_W-1:0] quo_in;
            logic [CNT_W:0]   trial;
            logic             take;

            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = i_num;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign num_in = r_num[k-1];
                assign quo_in = r_quo[k-1];
            end

            // bring down the next numerator bit, subtract if it fits
            assign trial = {rem_in, num_in[NUM_W-1-k]};
            assign take  = (trial >= {1'b0, i_den});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= take ? CNT_W'(trial - {1'b0, i_den}) : trial[CNT_W-1:0];
                    r_quo[k] <= {quo_in[NUM_W-2:0], take};
                    r_num[k] <= num_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[NUM_W-1];

endmodule

// ===== src/tsvg_sincos.sv =====
// ----------------------------------------------------------------------------
// Sine and cosine unit
// Registered quadrant fold, quarter-wave ROM read and sign apply, in that order.
// ----------------------------------------------------------------------------
module tsvg_sincos #(
    parameter  int DEPTH = 1024,
    localparam int PH_W  = $clog2(4 * DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [PH_W-1:0]                     i_phase,
    output logic signed [tsvg_pkg::NORM_W-1:0]  o_sin,
    output logic signed [tsvg_pkg::NORM_W-1:0]  o_cos
);
    import tsvg_pkg::*;

    localparam int AW   = $clog2(DEPTH + 1);
    localparam int TURN = 4 * DEPTH;

    typedef logic [FRAC_W:0] t_rom [0:DEPTH];

    // Quarter wave, odd Taylor series through x^15 in Q30, rounded to Q16
    function automatic t_rom rom_build();
        t_rom               tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        for (int k = 0; k <= DEPTH; k++) begin
            x    = (64'(k) * 64'd1686629713) / 64'(DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = '0;
            sum = (sum + 64'sd8192) >>> 14;
            if (sum > 64'sd65536)
                sum = 64'sd65536;
            tab[k] = sum[FRAC_W:0];
        end
        return tab;
    endfunction

    localparam t_rom ROM = rom_build();

    // {negate, table address} for a phase below one turn
    function automatic logic [AW:0] fold(input logic [PH_W-1:0] p);
        logic [1:0]      q;
        logic [PH_W-1:0] r;
        logic [AW-1:0]   addr;
        if (p >= PH_W'(3 * DEPTH)) begin
            q = 2'd3;
            r = p - PH_W'(3 * DEPTH);
        end else if (p >= PH_W'(2 * DEPTH)) begin
            q = 2'd2;
            r = p - PH_W'(2 * DEPTH);
        end else if (p >= PH_W'(DEPTH)) begin
            q = 2'd1;
            r = p - PH_W'(DEPTH);
        end else begin
            q = 2'd0;
            r = p;
        end
        addr = q[0] ? AW'(DEPTH) - AW'(r) : AW'(r);
        return {q[1], addr};
    endfunction

    logic [PH_W:0]   cos_sum;
    logic [PH_W-1:0] cos_phase;
    logic [AW:0]     s_fold;
    logic [AW:0]     c_fold;

    // cosine is a quarter turn ahead
    always_comb begin
        cos_sum   = {1'b0, i_phase} + (PH_W+1)'(DEPTH);
        cos_phase = (cos_sum >= (PH_W+1)'(TURN)) ? PH_W'(cos_sum - (PH_W+1)'(TURN))
                                                  : cos_sum[PH_W-1:0];
        s_fold    = fold(i_phase);
        c_fold    = fold(cos_phase);
    end

    logic [AW-1:0]  r_s_addr;
    logic [AW-1:0]  r_c_addr;
    logic           r_s_neg1;
    logic           r_c_neg1;
    logic [FRAC_W:0] r_s_mag;
    logic [FRAC_W:0] r_c_mag;
    logic           r_s_neg2;
    logic           r_c_neg2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // fold
            r_s_addr <= s_fold[AW-1:0];
            r_c_addr <= c_fold[AW-1:0];
            r_s_neg1 <= s_fold[AW];
            r_c_neg1 <= c_fold[AW];
            // table read
            r_s_mag  <= ROM[r_s_addr];
            r_c_mag  <= ROM[r_c_addr];
            r_s_neg2 <= r_s_neg1;
            r_c_neg2 <= r_c_neg1;
            // sign
            o_sin    <= r_s_neg2 ? -$signed(NORM_W'(r_s_mag)) : $signed(NORM_W'(r_s_mag));
            o_cos    <= r_c_neg2 ? -$signed(NORM_W'(r_c_mag)) : $signed(NORM_W'(r_c_mag));
        end
    end

endmodule

// ===== src/tsvg_delay.sv =====
// ----------------------------------------------------------------------------
// Sideband delay line
// Carries fields alongside the datapath so they meet it at the final stage.
// ----------------------------------------------------------------------------
module tsvg_delay #(
    parameter int WIDTH  = 8,
    parameter int STAGES = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_line [STAGES];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_data;
            for (int s = 1; s < STAGES; s++)
                r_line[s] <= r_line[s-1];
        end
    end

    assign o_data = r_line[STAGES-1];

endmodule

// ===== src/torus_strip_vertex_generator.sv =====
// Each grid point gives two vertices on one output port; the pipe takes a new
//   point only as the output pair register frees up.
// Pipeline stages: one per quotient bit in the dividers (DIV_W, the widest
//   numerator, 29 bits at default parameters), 3 for sin/cos, 4 for the
//   multiplies. Synchronous active-low reset clears valids, loads config.
// ----------------------------------------------------------------------------
// Torus strip vertex generator
// Turns a (ring, tube) grid point into the two triangle-strip vertices.
// ----------------------------------------------------------------------------
module torus_strip_vertex_generator #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tsvg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tsvg_pkg::CFG_W-1:0]            i_cfg_data,
    // grid point requests
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [tsvg_pkg::RING_W-1:0]           i_ring_index,
    input  logic [tsvg_pkg::TUBE_W-1:0]           i_tube_index,
    // vertices
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [tsvg_pkg::POS_W-1:0]     o_pos_x,
    output logic signed [tsvg_pkg::POS_W-1:0]     o_pos_y,
    output logic signed [tsvg_pkg::POS_W-1:0]     o_pos_z,
    output logic signed [tsvg_pkg::NORM_W-1:0]    o_norm_x,
    output logic signed [tsvg_pkg::NORM_W-1:0]    o_norm_y,
    output logic signed [tsvg_pkg::NORM_W-1:0]    o_norm_z,
    output logic [tsvg_pkg::TEX_W-1:0]            o_tex_u,
    output logic [tsvg_pkg::TEX_W-1:0]            o_tex_v,
    output logic [tsvg_pkg::SLOT_W-1:0]           o_vertex_slot,
    output logic                                  o_last
);
    import tsvg_pkg::*;

    localparam int TURN    = 4 * SINE_TABLE_DEPTH;
    localparam int PH_W    = $clog2(TURN);
    localparam int PNUM_W  = CNT_W + $clog2(TURN + 1);
    localparam int DIV_W   = (PNUM_W > TEX_NUM_W) ? PNUM_W : TEX_NUM_W;
    localparam int VLD_N   = DIV_W + 7;
    localparam logic [16:0] MAX_CNT = 17'(1) << COUNT_BITS;

    // ---------------- configuration registers ----------------
    logic [RAD_W-1:0] r_major;
    logic [RAD_W-1:0] r_minor;
    logic [CNT_W-1:0] r_ring_cnt;
    logic [CNT_W-1:0] r_tube_cnt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major    <= RAD_W'(65536);
            r_minor    <= RAD_W'(16384);
            r_ring_cnt <= CNT_W'(16);
            r_tube_cnt <= CNT_W'(16);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAJOR: r_major    <= i_cfg_data[RAD_W-1:0];
                CFG_MINOR: r_minor    <= i_cfg_data[RAD_W-1:0];
                CFG_RING:  r_ring_cnt <= i_cfg_data[CNT_W-1:0];
                CFG_TUBE:  r_tube_cnt <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts act as one, large counts stop at 2**COUNT_BITS
    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] c);
        if (c == '0)
            return CNT_W'(1);
        if ({4'b0, c} > MAX_CNT)
            return MAX_CNT[CNT_W-1:0];
        return c;
    endfunction

    logic [CNT_W-1:0] rc;
    logic [CNT_W-1:0] tc;
    assign rc = clamp_cnt(r_ring_cnt);
    assign tc = clamp_cnt(r_tube_cnt);

    // ---------------- flow control ----------------
    logic             en;
    logic             r_ov;
    logic             r_half;
    logic [VLD_N-1:0] r_vld;

    // whole pipe moves when the output pair register frees up
    assign en      = !r_ov || (r_half && !i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ov   <= 1'b0;
            r_half <= 1'b0;
        end else if (en) begin
            r_vld  <= {r_vld[VLD_N-2:0], i_valid};
            r_ov   <= r_vld[VLD_N-1];
            r_half <= 1'b0;
        end else if (r_ov && !i_stall) begin
            r_half <= 1'b1;
        end
    end

    // ---------------- stage 0: clamp indices, form numerators ----------------
    logic [RING_W-1:0] i_cl;
    logic [TUBE_W-1:0] j_cl;
    logic [CNT_W-1:0]  ring1;

    always_comb begin
        i_cl  = (CNT_W'(i_ring_index) > rc - CNT_W'(1)) ? RING_W'(rc - CNT_W'(1))
                                                        : i_ring_index;
        j_cl  = (i_tube_index > tc) ? tc : i_tube_index;
        ring1 = CNT_W'(i_cl) + CNT_W'(1);
    end

    logic [DIV_W-1:0]  r_pa0_num;
    logic [DIV_W-1:0]  r_pa1_num;
    logic [DIV_W-1:0]  r_pb_num;
    logic [DIV_W-1:0]  r_tu0_num;
    logic [DIV_W-1:0]  r_tu1_num;
    logic [DIV_W-1:0]  r_tv_num;
    logic [SLOT_W-1:0] r_slot0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa0_num <= DIV_W'(i_cl) * DIV_W'(TURN);
            r_pa1_num <= DIV_W'(ring1) * DIV_W'(TURN);
            r_pb_num  <= DIV_W'(j_cl) * DIV_W'(TURN);
            r_tu0_num <= DIV_W'(i_cl) << FRAC_W;
            r_tu1_num <= DIV_W'(ring1) << FRAC_W;
            r_tv_num  <= DIV_W'(j_cl) << FRAC_W;
            r_slot0   <= SLOT_W'((SLOT_W'(i_cl) * (SLOT_W'(tc) + SLOT_W'(1))
                                  + SLOT_W'(j_cl)) << 1);
        end
    end

    // ---------------- dividers ----------------
    logic [DIV_W-1:0] q_pa0;
    logic [DIV_W-1:0] q_pa1;
    logic [DIV_W-1:0] q_pb;
    logic [DIV_W-1:0] q_tu0;
    logic [DIV_W-1:0] q_tu1;
    logic [DIV_W-1:0] q_tv;

    tsvg_div #(.NUM_W(DIV_W)) u_div_pa0 (
        .i_clk(i_clk), .i_en(en), .i_num(r_pa0_num), .i_den(rc), .o_quo(q_pa0));
    tsvg_div #(.NUM_W(DIV_W)) u_div_pa1 (
        .i_clk(i_clk), .i_en(en), .i_num(r_pa1_num), .i_den(rc), .o_quo(q_pa1));
    tsvg_div #(.NUM_W(DIV_W)) u_div_pb (
        .i_clk(i_clk), .i_en(en), .i_num(r_pb_num), .i_den(tc), .o_quo(q_pb));
    tsvg_div #(.NUM_W(DIV_W)) u_div_tu0 (
        .i_clk(i_clk), .i_en(en), .i_num(r_tu0_num), .i_den(rc), .o_quo(q_tu0));
    tsvg_div #(.NUM_W(DIV_W)) u_div_tu1 (
        .i_clk(i_clk), .i_en(en), .i_num(r_tu1_num), .i_den(rc), .o_quo(q_tu1));
    tsvg_div #(.NUM_W(DIV_W)) u_div_tv (
        .i_clk(i_clk), .i_en(en), .i_num(r_tv_num), .i_den(tc), .o_quo(q_tv));

    // a full turn wraps to zero phase
    logic [PH_W-1:0] ph_a0;
    logic [PH_W-1:0] ph_a1;
    logic [PH_W-1:0] ph_b;
    assign ph_a0 = (q_pa0 >= DIV_W'(TURN)) ? '0 : q_pa0[PH_W-1:0];
    assign ph_a1 = (q_pa1 >= DIV_W'(TURN)) ? '0 : q_pa1[PH_W-1:0];
    assign ph_b  = (q_pb  >= DIV_W'(TURN)) ? '0 : q_pb[PH_W-1:0];

    // ---------------- sine / cosine ----------------
    logic signed [NORM_W-1:0] sa0, ca0, sa1, ca1, sb, cb;

    tsvg_sincos #(.DEPTH(SINE_TABLE_DEPTH)) u_sc_a0 (
        .i_clk(i_clk), .i_en(en), .i_phase(ph_a0), .o_sin(sa0), .o_cos(ca0));
    tsvg_sincos #(.DEPTH(SINE_TABLE_DEPTH)) u_sc_a1 (
        .i_clk(i_clk), .i_en(en), .i_phase(ph_a1), .o_sin(sa1), .o_cos(ca1));
    tsvg_sincos #(.DEPTH(SINE_TABLE_DEPTH)) u_sc_b (
        .i_clk(i_clk), .i_en(en), .i_phase(ph_b), .o_sin(sb), .o_cos(cb));

    // ---------------- sideband ----------------
    logic [3*TEX_W-1:0] tex_d;
    logic [SLOT_W-1:0]  slot_d;

    tsvg_delay #(.WIDTH(3 * TEX_W), .STAGES(6)) u_dly_tex (
        .i_clk(i_clk), .i_en(en),
        .i_data({q_tu0[TEX_W-1:0], q_tu1[TEX_W-1:0], q_tv[TEX_W-1:0]}),
        .o_data(tex_d));

    tsvg_delay #(.WIDTH(SLOT_W), .STAGES(DIV_W + 6)) u_dly_slot (
        .i_clk(i_clk), .i_en(en), .i_data(r_slot0), .o_data(slot_d));

    // ---------------- M1: radius and normal products ----------------
    logic signed [PROD_W-1:0] r_mc, r_ms;
    logic signed [2*NORM_W-1:0] r_nx0, r_ny0, r_nx1, r_ny1;
    logic signed [NORM_W-1:0] r1_ca0, r1_sa0, r1_ca1, r1_sa1, r1_sb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mc   <= $signed({1'b0, r_minor}) * cb;
            r_ms   <= $signed({1'b0, r_minor}) * sb;
            r_nx0  <= ca0 * cb;
            r_ny0  <= sa0 * cb;
            r_nx1  <= ca1 * cb;
            r_ny1  <= sa1 * cb;
            r1_ca0 <= ca0;
            r1_sa0 <= sa0;
            r1_ca1 <= ca1;
            r1_sa1 <= sa1;
            r1_sb  <= sb;
        end
    end

    // ---------------- M2: tube radius sum, z, normals ----------------
    logic [POS_W-1:0]  mc_q;
    logic [PROD_W-1:0] rsum;

    always_comb begin
        mc_q = sat32(PROD_W'(r_mc >>> FRAC_W));
        rsum = PROD_W'($signed(mc_q)) + PROD_W'({1'b0, r_major});
    end

    logic signed [POS_W-1:0]  r_rad, r2_z;
    logic signed [NORM_W-1:0] r2_nx0, r2_ny0, r2_nx1, r2_ny1, r2_nz;
    logic signed [NORM_W-1:0] r2_ca0, r2_sa0, r2_ca1, r2_sa1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad  <= sat32(rsum);
            r2_z   <= sat32(PROD_W'(r_ms >>> FRAC_W));
            r2_nx0 <= r_nx0[FRAC_W+NORM_W-1:FRAC_W];
            r2_ny0 <= r_ny0[FRAC_W+NORM_W-1:FRAC_W];
            r2_nx1 <= r_nx1[FRAC_W+NORM_W-1:FRAC_W];
            r2_ny1 <= r_ny1[FRAC_W+NORM_W-1:FRAC_W];
            r2_nz  <= r1_sb;
            r2_ca0 <= r1_ca0;
            r2_sa0 <= r1_sa0;
            r2_ca1 <= r1_ca1;
            r2_sa1 <= r1_sa1;
        end
    end

    // ---------------- M3: ring position products ----------------
    logic signed [PROD_W-1:0] r_px0, r_py0, r_px1, r_py1;
    logic signed [POS_W-1:0]  r3_z;
    logic signed [NORM_W-1:0] r3_nx0, r3_ny0, r3_nx1, r3_ny1, r3_nz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px0  <= r2_ca0 * r_rad;
            r_py0  <= r2_sa0 * r_rad;
            r_px1  <= r2_ca1 * r_rad;
            r_py1  <= r2_sa1 * r_rad;
            r3_z   <= r2_z;
            r3_nx0 <= r2_nx0;
            r3_ny0 <= r2_ny0;
            r3_nx1 <= r2_nx1;
            r3_ny1 <= r2_ny1;
            r3_nz  <= r2_nz;
        end
    end

    // ---------------- M4: output pair register ----------------
    logic signed [POS_W-1:0]  r_ox0, r_oy0, r_ox1, r_oy1, r_oz;
    logic signed [NORM_W-1:0] r_onx0, r_ony0, r_onx1, r_ony1, r_onz;
    logic [TEX_W-1:0]         r_tu0, r_tu1, r_tv;
    logic [SLOT_W-1:0]        r_slot;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox0  <= sat32(PROD_W'(r_px0 >>> FRAC_W));
            r_oy0  <= sat32(PROD_W'(r_py0 >>> FRAC_W));
            r_ox1  <= sat32(PROD_W'(r_px1 >>> FRAC_W));
            r_oy1  <= sat32(PROD_W'(r_py1 >>> FRAC_W));
            r_oz   <= r3_z;
            r_onx0 <= r3_nx0;
            r_ony0 <= r3_ny0;
            r_onx1 <= r3_nx1;
            r_ony1 <= r3_ny1;
            r_onz  <= r3_nz;
            r_tu0  <= tex_d[3*TEX_W-1:2*TEX_W];
            r_tu1  <= tex_d[2*TEX_W-1:TEX_W];
            r_tv   <= tex_d[TEX_W-1:0];
            r_slot <= slot_d;
        end
    end

    // ring i vertex first, then ring i+1
    assign o_valid       = r_ov;
    assign o_pos_x       = r_half ? r_ox1 : r_ox0;
    assign o_pos_y       = r_half ? r_oy1 : r_oy0;
    assign o_pos_z       = r_oz;
    assign o_norm_x      = r_half ? r_onx1 : r_onx0;
    assign o_norm_y      = r_half ? r_ony1 : r_ony0;
    assign o_norm_z      = r_onz;
    assign o_tex_u       = r_half ? r_tu1 : r_tu0;
    assign o_tex_v       = r_tv;
    assign o_vertex_slot = {r_slot[SLOT_W-1:1], r_half};
    assign o_last        = r_half;

endmodule

// ===== src/tsvg_checker.sv =====
// ----------------------------------------------------------------------------
// Torus strip vertex generator port checker
// Watches the output side for pairing, slot order and reset behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsvg_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_stall,
    input logic                                  o_valid,
    input logic                                  o_last,
    input logic [tsvg_pkg::SLOT_W-1:0]           o_vertex_slot,
    input logic signed [tsvg_pkg::POS_W-1:0]     o_pos_x
);
    import tsvg_pkg::*;

    // nothing comes out right after reset
    `ASSERT_NEXT_ALWAYS(a_rst_idle, i_clk, !i_rst_n, !o_valid)

    // the second vertex follows the first at once
    `ASSERT_NEXT(a_pair, i_clk, i_rst_n, o_valid && !i_stall && !o_last, o_valid && o_last)

    // second vertex sits in the next buffer slot
    `ASSERT_NEXT(a_slot, i_clk, i_rst_n, o_valid && !i_stall && !o_last, o_vertex_slot == SLOT_W'($past(o_vertex_slot) + 1'b1))

    // a stalled vertex is held
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_pos_x) && $stable(o_last))

endmodule

bind torus_strip_vertex_generator tsvg_checker u_tsvg_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Torus strip vertex generator testbench
// Sends grid-point requests through the block under random idling and
// backpressure, predicts both strip vertices of each point with its own
// fixed-point torus math, and checks every vertex in order.
// ----------------------------------------------------------------------------
module testbench;
    import tsvg_pkg::*;

    // Expected strip vertex
    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [17:0] norm_x;
        logic [17:0] norm_y;
        logic [17:0] norm_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [25:0] slot;
        logic        last;
    } t_vertex;

    class torus_scoreboard;
        localparam longint DEPTH = 1024;
        localparam longint TURN  = 4 * DEPTH;

        longint    major_r;
        longint    minor_r;
        longint    rings;
        longint    tubes;
        longint    quarter_wave[0:1024];
        t_vertex   pending[$];
        int        errors;
        int        checked;

        function new();
            longint x, x2, term, sum;
            for (int k = 0; k <= DEPTH; k++) begin
                x = (longint'(k) * 64'd1686629713) / DEPTH;
                x2 = (x * x) >>> 30;
                term = x;
                sum = x;
                for (int n = 1; n <= 7; n++) begin
                    term = ((term * x2) >>> 30) / ((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) sum -= term;
                    else sum += term;
                end
                if (sum < 0) sum = 0;
                sum = (sum + 8192) >>> 14;
                if (sum > 65536) sum = 65536;
                quarter_wave[k] = sum;
            end
            load_defaults();
            errors = 0;
            checked = 0;
        endfunction

        function void load_defaults();
            major_r = 65536;
            minor_r = 16384;
            rings = 16;
            tubes = 16;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_MAJOR: major_r = data[30:0];
                CFG_MINOR: minor_r = data[30:0];
                CFG_RING:  rings = data[12:0];
                CFG_TUBE:  tubes = data[12:0];
                default: ;
            endcase
        endfunction

        function longint sine(longint phase);
            longint p, q, r, v;
            p = phase % TURN;
            q = p / DEPTH;
            r = p % DEPTH;
            v = q[0] ? quarter_wave[DEPTH - r] : quarter_wave[r];
            return q[1] ? -v : v;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Q16.16 product, floor, saturated
        function longint fmul(longint a, longint b);
            return clip32((a * b) >>> 16);
        endfunction

        function longint clamp_count(longint c);
            if (c == 0) return 1;
            if (c > 4096) return 4096;
            return c;
        endfunction

        // Note an accepted grid point: queue its two vertices
        function void note_point(logic [11:0] ring_in, logic [12:0] tube_in);
            longint rc, tc, i, j, pb, cb, sb, rad, z, ring, pa, ca, sa;
            t_vertex v;
            rc = clamp_count(rings);
            tc = clamp_count(tubes);
            i = ring_in;
            j = tube_in;
            if (i > rc - 1) i = rc - 1;
            if (j > tc) j = tc;
            pb = (j * TURN) / tc;
            cb = sine(pb + DEPTH);
            sb = sine(pb);
            rad = clip32(fmul(minor_r, cb) + major_r);
            z = fmul(minor_r, sb);
            for (int k = 0; k < 2; k++) begin
                ring = i + k;
                pa = (ring * TURN) / rc;
                ca = sine(pa + DEPTH);
                sa = sine(pa);
                v.pos_x = fmul(ca, rad);
                v.pos_y = fmul(sa, rad);
                v.pos_z = z;
                v.norm_x = fmul(ca, cb);
                v.norm_y = fmul(sa, cb);
                v.norm_z = sb;
                v.tex_u = (ring << 16) / rc;
                v.tex_v = (j << 16) / tc;
                v.slot = (i * (tc + 1) + j) * 2 + k;
                v.last = k[0];
                pending.push_back(v);
            end
        endfunction

        task check_vertex(t_vertex got);
            t_vertex e;
            if (pending.size() == 0) begin
                report_mismatch("vertex with nothing pending", 0, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.pos_x !== e.pos_x) report_mismatch("pos_x", got.pos_x, e.pos_x);
            if (got.pos_y !== e.pos_y) report_mismatch("pos_y", got.pos_y, e.pos_y);
            if (got.pos_z !== e.pos_z) report_mismatch("pos_z", got.pos_z, e.pos_z);
            if (got.norm_x !== e.norm_x) report_mismatch("norm_x", got.norm_x, e.norm_x);
            if (got.norm_y !== e.norm_y) report_mismatch("norm_y", got.norm_y, e.norm_y);
            if (got.norm_z !== e.norm_z) report_mismatch("norm_z", got.norm_z, e.norm_z);
            if (got.tex_u !== e.tex_u) report_mismatch("tex_u", got.tex_u, e.tex_u);
            if (got.tex_v !== e.tex_v) report_mismatch("tex_v", got.tex_v, e.tex_v);
            if (got.slot !== e.slot) report_mismatch("vertex_slot", got.slot, e.slot);
            if (got.last !== e.last) report_mismatch("last", got.last, e.last);
        endtask

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 40)
                $display("MISMATCH vertex %0d %s: got %h want %h", checked, what, got, want);
        endtask
    endclass

    localparam int TAIL_CYCLES = 200;
    localparam int WATCHDOG    = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_MAJOR;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [11:0] i_ring_index = '0;
    logic [12:0] i_tube_index = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [17:0] o_norm_x, o_norm_y, o_norm_z;
    logic [16:0] o_tex_u, o_tex_v;
    logic [25:0] o_vertex_slot;
    logic        o_last;

    torus_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  hold_output = 1'b0;
    bit  stim_done = 1'b0;
    int  points_sent = 0;

    torus_strip_vertex_generator uut (.*);

    always #10 i_clk = ~i_clk;

    // Short gaps mostly, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Output side: random stall, checks on accepted vertices
    always @(posedge i_clk) begin
        t_vertex got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.pos_x = o_pos_x; got.pos_y = o_pos_y; got.pos_z = o_pos_z;
            got.norm_x = o_norm_x; got.norm_y = o_norm_y; got.norm_z = o_norm_z;
            got.tex_u = o_tex_u; got.tex_v = o_tex_v;
            got.slot = o_vertex_slot; got.last = o_last;
            sb.check_vertex(got);
        end
    end

    initial begin : out_stall
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_output) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_output = 1'b0;
            end
            n = gap_len();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // Watchdog on cycles with no accepted request, vertex or config write
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Watchdog expired with %0d vertices pending", sb.pending.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_point(logic [11:0] ring, logic [12:0] tube, bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ring_index <= ring;
        i_tube_index <= tube;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_point(ring, tube);
        points_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Valid stays up across a run of writes; set_all drops it at the end
    task automatic write_cfg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_all(logic [31:0] maj, logic [31:0] mnr, logic [31:0] rc,
                           logic [31:0] tc);
        write_cfg(CFG_MAJOR, maj);
        write_cfg(CFG_MINOR, mnr);
        write_cfg(CFG_RING, rc);
        write_cfg(CFG_TUBE, tc);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly in-range points, some at the top corner, some fully random
    task automatic random_points(int count);
        longint rc, tc;
        logic [11:0] r;
        logic [12:0] t;
        rc = sb.clamp_count(sb.rings);
        tc = sb.clamp_count(sb.tubes);
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: begin r = $urandom; t = $urandom; end
                1: begin r = rc - 1; t = tc; end
                default: begin
                    r = $urandom_range(0, rc - 1);
                    t = $urandom_range(0, tc);
                end
            endcase
            send_point(r, t, 1'b1);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, extremes of both indices
        send_point(0, 0, 1'b0);
        send_point(15, 16, 1'b0);
        send_point(12'hFFF, 13'h1FFF, 1'b0);
        send_point(7, 4, 1'b0);
        send_point(3, 12, 1'b0);
        drain();
        // Zero counts act as one, zero minor radius
        set_all(0, 0, 0, 0);
        send_point(0, 0, 1'b0);
        send_point(5, 1, 1'b0);
        send_point(0, 13'h1FFF, 1'b0);
        drain();
        // Largest radii saturate, counts above the maximum clamp
        set_all(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1FFF, 32'h1FFF);
        send_point(0, 0, 1'b0);
        send_point(12'hFFF, 13'h1000, 1'b0);
        send_point(12'hAAA, 13'h0555, 1'b0);
        send_point(12'h555, 13'h1AAA, 1'b0);
        drain();
        set_all(32'h4000_0000, 32'h0001_0000, 4096, 4096);
        send_point(1024, 2048, 1'b0);
        send_point(3072, 3072, 1'b0);
        send_point(2048, 1024, 1'b0);
        drain();

        // Random phases across several settings
        set_all(65536, 16384, 16, 16);
        random_points(250);
        hold_output = 1'b1;
        random_points(150);
        drain();
        set_all($urandom, $urandom, $urandom_range(1, 64), $urandom_range(1, 64));
        random_points(300);
        drain();
        set_all($urandom_range(0, 32'h0100_0000), $urandom_range(1, 32'h0080_0000),
                $urandom_range(1, 4096), $urandom_range(1, 4096));
        random_points(300);
        drain();
        set_all(32'h7FFF_FFFF, 1, 1, 1);
        random_points(150);
        drain();
        set_all($urandom, $urandom, $urandom_range(1, 8), $urandom_range(4000, 8191));
        random_points(300);
        drain();
        set_all(32'h0010_0000, 32'h0008_0000, 3, 7);
        random_points(300);
        drain();
        stim_done = 1'b1;

        fork
            begin
                repeat (TAIL_CYCLES) @(posedge i_clk);
            end
        join
        $display("Sent %0d grid points over ten register settings, checked %0d vertices",
                 points_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== torus_strip_vertex_generator.f =====
+incdir+src
src/tsvg_pkg.sv
src/tsvg_div.sv
src/tsvg_sincos.sv
src/tsvg_delay.sv
src/torus_strip_vertex_generator.sv
src/tsvg_checker.sv
bench/testbench.sv
